### src/shfw_pkg.sv
package shfw_pkg;

  localparam int unsigned COUNT_WIDTH_DEF = 32;
  localparam int unsigned TIME_WIDTH_DEF  = 48;

  localparam int unsigned THR_W     = 40;
  localparam int unsigned STAGE_W   = 5;
  localparam int unsigned SSTAGE_W  = 4;

  localparam int unsigned APB_DATA_W = 64;
  localparam int unsigned APB_ADDR_W = 5;

  localparam logic [THR_W-1:0]    SERVING_THR_RST   = THR_W'(30000000);
  localparam logic [THR_W-1:0]    BOOT_THR_RST      = THR_W'(600000000);
  localparam logic [SSTAGE_W-1:0] SERVING_STAGE_RST = SSTAGE_W'(8);

  typedef enum logic [1:0] {
    REG_SERVING_THR   = 2'd0,
    REG_BOOT_THR      = 2'd1,
    REG_SERVING_STAGE = 2'd2
  } shfw_reg_e;

endpackage

### src/shfw_in_if.sv
interface shfw_in_if #(
  parameter int unsigned COUNT_WIDTH = shfw_pkg::COUNT_WIDTH_DEF,
  parameter int unsigned TIME_WIDTH  = shfw_pkg::TIME_WIDTH_DEF
);
  logic                               valid;
  logic                               ready;
  logic [COUNT_WIDTH-1:0]             sweep_count;
  logic [COUNT_WIDTH-1:0]             boot_count;
  logic signed [shfw_pkg::STAGE_W-1:0] stage;
  logic [TIME_WIDTH-1:0]              now_time;
  logic                               unsupervised;

  modport source (
    output valid, sweep_count, boot_count, stage, now_time, unsupervised,
    input  ready
  );
  modport sink (
    input  valid, sweep_count, boot_count, stage, now_time, unsupervised,
    output ready
  );
endinterface

### src/shfw_out_if.sv
interface shfw_out_if;
  logic                       valid;
  logic                       ready;
  logic                       freeze_declared;
  logic                       respawn_request;
  logic [shfw_pkg::THR_W-1:0] budget_used;

  modport source (
    output valid, freeze_declared, respawn_request, budget_used,
    input  ready
  );
  modport sink (
    input  valid, freeze_declared, respawn_request, budget_used,
    output ready
  );
endinterface

### src/staged_heartbeat_freeze_watchdog.sv
// Channel   Dir  Handshake     Payload
// in_ch     in   valid/ready   sweep_count, boot_count, stage, now_time, unsupervised
// out_ch    out  valid/ready   freeze_declared, respawn_request, budget_used
// apb       in   psel/penable  serving_threshold @0x00, boot_threshold @0x08,
//                              serving_stage @0x10
//
// One poll per cycle sustained while the result register is not stalled; a poll's result
// passes through the input register, then the result register with the watchdog state.
// Reset returns the thresholds to their defaults and clears all episode state.
// A stalled result register holds the input register; the input side keeps
// taking requests as long as the input register can move on.
module staged_heartbeat_freeze_watchdog #(
  parameter int unsigned COUNT_WIDTH = shfw_pkg::COUNT_WIDTH_DEF,
  parameter int unsigned TIME_WIDTH  = shfw_pkg::TIME_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [shfw_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [shfw_pkg::APB_DATA_W-1:0] pwdata,
  output logic [shfw_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready,
  shfw_in_if.sink                         in_ch,
  shfw_out_if.source                      out_ch
);

  localparam int unsigned THR_W = shfw_pkg::THR_W;
  localparam int unsigned CMP_W = (TIME_WIDTH > THR_W) ? TIME_WIDTH : THR_W;

  // Configuration registers
  logic [THR_W-1:0]              serving_thr_q, boot_thr_q;
  logic [shfw_pkg::SSTAGE_W-1:0] serving_stage_q;
  logic                          cfg_wr;
  shfw_pkg::shfw_reg_e           cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_sel = shfw_pkg::shfw_reg_e'(paddr[4:3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      serving_thr_q   <= shfw_pkg::SERVING_THR_RST;
      boot_thr_q      <= shfw_pkg::BOOT_THR_RST;
      serving_stage_q <= shfw_pkg::SERVING_STAGE_RST;
    end else if (cfg_wr) begin
      case (cfg_sel)
        shfw_pkg::REG_SERVING_THR:   serving_thr_q   <= pwdata[THR_W-1:0];
        shfw_pkg::REG_BOOT_THR:      boot_thr_q      <= pwdata[THR_W-1:0];
        shfw_pkg::REG_SERVING_STAGE: serving_stage_q <= pwdata[shfw_pkg::SSTAGE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      shfw_pkg::REG_SERVING_THR:   prdata = shfw_pkg::APB_DATA_W'(serving_thr_q);
      shfw_pkg::REG_BOOT_THR:      prdata = shfw_pkg::APB_DATA_W'(boot_thr_q);
      shfw_pkg::REG_SERVING_STAGE: prdata = shfw_pkg::APB_DATA_W'(serving_stage_q);
      default:                     prdata = '0;
    endcase
  end

  // Input register
  logic                         in_acc, out_adv, s2_fire;
  logic                         s1_valid_q, s1_valid_d;
  logic [COUNT_WIDTH-1:0]       s1_live_q;
  logic [shfw_pkg::STAGE_W-1:0] s1_stage_q;
  logic [TIME_WIDTH-1:0]        s1_now_q;
  logic                         s1_unsup_q;

  assign out_adv     = !out_ch.valid || out_ch.ready;
  assign s2_fire     = s1_valid_q && out_adv;
  assign in_ch.ready = !s1_valid_q || out_adv;
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end else if (out_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_live_q  <= in_ch.sweep_count + in_ch.boot_count;
      s1_stage_q <= in_ch.stage;
      s1_now_q   <= in_ch.now_time;
      s1_unsup_q <= in_ch.unsupervised;
    end
  end

  // Watchdog state
  logic                   seeded_q, seeded_d;
  logic [COUNT_WIDTH-1:0] last_live_q, last_live_d;
  logic [TIME_WIDTH-1:0]  last_chg_q, last_chg_d;
  logic                   fired_q, fired_d;
  logic [TIME_WIDTH-1:0]  last_poll_q;
  logic                   respawn_q, respawn_d;

  logic                   serving_on, boot_sel, gap, elapsed, freeze_d;
  logic [THR_W-1:0]       budget;
  logic [TIME_WIDTH-1:0]  poll_diff, chg_diff;

  assign serving_on = serving_thr_q != '0;
  assign boot_sel   = serving_on && !s1_stage_q[shfw_pkg::STAGE_W-1]
                      && (s1_stage_q[shfw_pkg::SSTAGE_W-1:0] < serving_stage_q)
                      && (boot_thr_q > serving_thr_q);
  assign budget     = boot_sel ? boot_thr_q : serving_thr_q;

  assign poll_diff = s1_now_q - last_poll_q;
  assign chg_diff  = s1_now_q - last_chg_q;

  // A long silence between polls starts a fresh episode
  assign gap = (last_poll_q != '0) && (s1_now_q > last_poll_q) && serving_on
               && (CMP_W'(poll_diff) >= CMP_W'(serving_thr_q));

  // Time running backward counts as not elapsed
  assign elapsed = (s1_now_q >= last_chg_q) && (CMP_W'(chg_diff) >= CMP_W'(budget));

  always_comb begin
    seeded_d    = 1'b1;
    last_live_d = last_live_q;
    last_chg_d  = last_chg_q;
    fired_d     = fired_q;
    respawn_d   = respawn_q;
    freeze_d    = 1'b0;
    if (!seeded_q || gap || (s1_live_q != last_live_q)) begin
      last_live_d = s1_live_q;
      last_chg_d  = s1_now_q;
      fired_d     = 1'b0;
    end else if (!fired_q && (budget != '0) && elapsed) begin
      fired_d  = 1'b1;
      freeze_d = 1'b1;
      if (s1_unsup_q) begin
        respawn_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seeded_q    <= 1'b0;
      last_live_q <= '0;
      last_chg_q  <= '0;
      fired_q     <= 1'b0;
      last_poll_q <= '0;
      respawn_q   <= 1'b0;
    end else if (s2_fire) begin
      seeded_q    <= seeded_d;
      last_live_q <= last_live_d;
      last_chg_q  <= last_chg_d;
      fired_q     <= fired_d;
      last_poll_q <= s1_now_q;
      respawn_q   <= respawn_d;
    end
  end

  // Result register
  logic             out_valid_q, out_valid_d;
  logic             out_freeze_q, out_respawn_q;
  logic [THR_W-1:0] out_budget_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_adv) begin
      out_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_fire) begin
      out_freeze_q  <= freeze_d;
      out_respawn_q <= respawn_d;
      out_budget_q  <= budget;
    end
  end

  assign out_ch.valid           = out_valid_q;
  assign out_ch.freeze_declared = out_freeze_q;
  assign out_ch.respawn_request = out_respawn_q;
  assign out_ch.budget_used     = out_budget_q;

  a_respawn_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    respawn_q |=> respawn_q)
    else $error("respawn request dropped");

  a_freeze_sets_fired: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_fire && freeze_d) |=> (fired_q && out_ch.valid && out_ch.freeze_declared))
    else $error("declared freeze not recorded");

  a_freeze_needs_budget: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_fire && freeze_d) |-> (budget != '0 && seeded_q && !fired_q))
    else $error("freeze declared outside an armed episode");

  a_stall_holds_poll: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !out_adv) |=> (s1_valid_q && $stable(s1_now_q)))
    else $error("pending poll lost under stall");

endmodule
